// File: design/apc_pkg.sv
// Shared types and constants of the affine permutation letter cipher.
package apc_pkg;

    // Size of the letter alphabet and the address width of the tables.
    localparam int ALPHABET_SIZE = 26;
    localparam int TBL_AW        = $clog2(ALPHABET_SIZE);

    // Letter index and table value width, fixed by the word fields.
    localparam int VAL_W = 5;
    localparam logic [VAL_W-1:0] ALPHA_N    = VAL_W'(ALPHABET_SIZE);
    localparam logic [VAL_W-1:0] ALPHA_LAST = VAL_W'(ALPHABET_SIZE - 1);

    // ASCII constants for letter detection.
    localparam logic [7:0] ASCII_A       = 8'd65;
    localparam logic [7:0] ASCII_Z       = 8'd90;
    localparam logic [7:0] CASE_BIT      = 8'd32;
    localparam logic [7:0] ASCII_LOWER_A = ASCII_A + CASE_BIT;
    localparam logic [7:0] ASCII_LOWER_Z = ASCII_Z + CASE_BIT;

    // Remainder unit sizing: a magnitude below 1024 needs ten reduction steps.
    localparam int MAG_W           = 10;
    localparam int MOD_STEPS       = MAG_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int MOD_STAGES      = MOD_STEPS / STEPS_PER_STAGE;
    localparam int TRIAL_W         = MAG_W + VAL_W;

    // Word kinds.
    localparam logic KIND_CIPHER = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT_MODE = 3'd0,
        CFG_MODULUS      = 3'd1,
        CFG_MULTIPLIER   = 3'd2,
        CFG_SHIFT        = 3'd3,
        CFG_INV_MULT     = 3'd4,
        CFG_USE_TABLE    = 3'd5
    } apc_cfg_t;

    // Input word.
    typedef struct packed {
        logic             kind;
        logic [7:0]       char_in;
        logic [VAL_W-1:0] entry_index;
        logic [VAL_W-1:0] entry_value;
    } apc_in_t;

    // Result word.
    typedef struct packed {
        logic [7:0] char_out;
        logic       was_letter;
    } apc_out_t;

    // Side information that travels with a word through the remainder unit.
    typedef struct packed {
        logic             kind;
        logic             letter;
        logic [7:0]       ch;
        logic             neg;
        logic [VAL_W-1:0] ld_index;
        logic [VAL_W-1:0] ld_value;
    } apc_tag_t;

endpackage

// File: design/apc_mod_pipe.sv
// Pipelined restoring remainder unit: magnitude mod a small modulus, two steps per stage.
module apc_mod_pipe
    import apc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_vld,
    input  apc_tag_t         in_tag,
    input  logic [MAG_W-1:0] in_mag,
    input  logic [VAL_W-1:0] modulus,
    output logic             out_vld,
    output apc_tag_t         out_tag,
    output logic [VAL_W-1:0] out_rem
);

    logic             vld_reg [MOD_STAGES];
    apc_tag_t         tag_reg [MOD_STAGES];
    logic [MAG_W-1:0] rem_reg [MOD_STAGES];

    logic [MAG_W-1:0] stg_in  [MOD_STAGES];
    logic [MAG_W-1:0] stg_out [MOD_STAGES];

    // Each stage subtracts the shifted modulus wherever it fits, highest shift first.
    always_comb begin
        logic [MAG_W-1:0]   r;
        logic [TRIAL_W-1:0] trial;
        stg_in[0] = in_mag;
        for (int s = 1; s < MOD_STAGES; s++) begin
            stg_in[s] = rem_reg[s-1];
        end
        for (int s = 0; s < MOD_STAGES; s++) begin
            r = stg_in[s];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                trial = TRIAL_W'(modulus) << (MOD_STEPS - 1 - (s * STEPS_PER_STAGE + j));
                if (TRIAL_W'(r) >= trial) begin
                    r = r - trial[MAG_W-1:0];
                end
            end
            stg_out[s] = r;
        end
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < MOD_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < MOD_STAGES; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < MOD_STAGES; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int s = 0; s < MOD_STAGES; s++) begin
                rem_reg[s] <= stg_out[s];
            end
        end
    end

    assign out_vld = vld_reg[MOD_STAGES-1];
    assign out_tag = tag_reg[MOD_STAGES-1];
    assign out_rem = rem_reg[MOD_STAGES-1][VAL_W-1:0];

endmodule

// File: design/affine_permutation_letter_cipher_core.sv
// Top level of the affine permutation letter cipher.
//
//   Channel   Ports                                   Direction  Word
//   s_        s_valid, s_ready, s_data               in         apc_in_t
//   m_        m_valid, m_ready, m_data               out        apc_out_t
//   cfg_      cfg_valid, cfg_ready, cfg_index/_data  in         register write
//
// One word is taken per cycle unless a stall holds it; a cipher word's result shows on m_valid after the stages below.
// The pipeline is: forward table read, multiply, five remainder stages, inverse table
// read, output register. All stages advance together when the output register is free
// or being taken, so a stall on m_ready holds every stage and drops s_ready.
// Reset is synchronous; the tables read as identity through per-entry valid flags
// that reset clears at once, so no clearing pass is needed. Load words give no result.
module affine_permutation_letter_cipher_core
    import apc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  apc_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output apc_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic             decrypt_reg;
    logic [VAL_W-1:0] modulus_reg;
    logic [VAL_W-1:0] mult_reg;
    logic [VAL_W-1:0] shift_reg;
    logic [VAL_W-1:0] inv_mult_reg;
    logic             use_table_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg   <= 1'b0;
            modulus_reg   <= ALPHA_N;
            mult_reg      <= VAL_W'(1);
            shift_reg     <= '0;
            inv_mult_reg  <= VAL_W'(1);
            use_table_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (apc_cfg_t'(cfg_index))
                CFG_DECRYPT_MODE: decrypt_reg   <= cfg_data[0];
                CFG_MODULUS:      modulus_reg   <= cfg_data;
                CFG_MULTIPLIER:   mult_reg      <= cfg_data;
                CFG_SHIFT:        shift_reg     <= cfg_data;
                CFG_INV_MULT:     inv_mult_reg  <= cfg_data;
                CFG_USE_TABLE:    use_table_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A zero modulus behaves as modulus one.
    logic [VAL_W-1:0] mod_eff;
    assign mod_eff = (modulus_reg == '0) ? VAL_W'(1) : modulus_reg;

    // Permutation by the reversed alphabet or a table entry; out of range passes through.
    function automatic logic [VAL_W-1:0] permute(input logic [VAL_W-1:0] v,
                                                 input logic use_tbl,
                                                 input logic ok,
                                                 input logic [VAL_W-1:0] tdata);
        logic [VAL_W-1:0] res;
        if (v >= ALPHA_N) begin
            res = v;
        end else if (use_tbl) begin
            res = ok ? tdata : v;
        end else begin
            res = ALPHA_LAST - v;
        end
        return res;
    endfunction

    // Global advance: every stage moves when the output register can take a word.
    logic m_valid_reg;
    logic advance;
    logic accept;
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // Letter detection on the incoming word.
    logic [7:0]       in_up;
    logic             in_letter;
    logic [VAL_W-1:0] in_x;

    always_comb begin
        in_up = s_data.char_in;
        if (s_data.char_in >= ASCII_LOWER_A && s_data.char_in <= ASCII_LOWER_Z) begin
            in_up = s_data.char_in - CASE_BIT;
        end
        in_letter = (in_up >= ASCII_A) && (in_up <= ASCII_Z);
        in_x      = VAL_W'(in_up - ASCII_A);
    end

    // Forward table: written by load words and read by cipher words when taken.
    logic [VAL_W-1:0]         fwd_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] fwd_vld_reg;
    logic                     fwd_we;
    logic [TBL_AW-1:0]        fwd_waddr;
    logic [TBL_AW-1:0]        fwd_raddr;
    logic [VAL_W-1:0]         fwd_rd_reg;
    logic                     fwd_ok_reg;

    assign fwd_we    = accept && (s_data.kind == KIND_LOAD) && (s_data.entry_index < ALPHA_N);
    assign fwd_waddr = s_data.entry_index[TBL_AW-1:0];
    assign fwd_raddr = in_x[TBL_AW-1:0];

    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_waddr] <= s_data.entry_value;
        end
        if (accept) begin
            fwd_rd_reg <= fwd_mem[fwd_raddr];
            fwd_ok_reg <= fwd_vld_reg[fwd_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= '0;
        end else if (fwd_we) begin
            fwd_vld_reg[fwd_waddr] <= 1'b1;
        end
    end

    // Stage 1: decoded word.
    logic             s1_vld_reg;
    apc_tag_t         s1_tag_reg;
    logic [VAL_W-1:0] s1_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (advance) begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tag_reg.kind     <= s_data.kind;
            s1_tag_reg.letter   <= in_letter;
            s1_tag_reg.ch       <= s_data.char_in;
            s1_tag_reg.neg      <= 1'b0;
            s1_tag_reg.ld_index <= s_data.entry_index;
            s1_tag_reg.ld_value <= s_data.entry_value;
            s1_x_reg            <= in_x;
        end
    end

    // Stage 2 logic: permute and multiply-add for encryption, subtract then multiply for decryption, on magnitudes.
    logic [VAL_W-1:0] s1_perm;
    logic             s1_neg;
    logic [VAL_W-1:0] s1_op1;
    logic [VAL_W-1:0] s1_op2;
    logic [MAG_W-1:0] s1_mag;
    apc_tag_t         s1_tag_next;

    always_comb begin
        s1_perm = permute(s1_x_reg, use_table_reg, fwd_ok_reg, fwd_rd_reg);
        s1_neg  = decrypt_reg && (s1_x_reg < shift_reg);
        if (decrypt_reg) begin
            s1_op1 = s1_neg ? (shift_reg - s1_x_reg) : (s1_x_reg - shift_reg);
            s1_op2 = inv_mult_reg;
        end else begin
            s1_op1 = s1_perm;
            s1_op2 = mult_reg;
        end
        s1_mag = MAG_W'(s1_op1) * MAG_W'(s1_op2);
        if (!decrypt_reg) begin
            s1_mag = s1_mag + MAG_W'(shift_reg);
        end
        s1_tag_next     = s1_tag_reg;
        s1_tag_next.neg = s1_neg;
    end

    // Stage 2 registers: signed product as magnitude and sign.
    logic             s2_vld_reg;
    apc_tag_t         s2_tag_reg;
    logic [MAG_W-1:0] s2_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (advance) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_tag_reg <= s1_tag_next;
            s2_mag_reg <= s1_mag;
        end
    end

    // Remainder of the magnitude by the modulus.
    logic             mp_vld;
    apc_tag_t         mp_tag;
    logic [VAL_W-1:0] mp_rem;

    apc_mod_pipe u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (advance),
        .in_vld  (s2_vld_reg),
        .in_tag  (s2_tag_reg),
        .in_mag  (s2_mag_reg),
        .modulus (mod_eff),
        .out_vld (mp_vld),
        .out_tag (mp_tag),
        .out_rem (mp_rem)
    );

    // Floored remainder: a negative product with a nonzero remainder folds to m - r.
    logic [VAL_W-1:0] aff_r;
    assign aff_r = (mp_tag.neg && (mp_rem != '0)) ? (mod_eff - mp_rem) : mp_rem;

    // Inverse table: written by load words and read by cipher words at this stage.
    logic [VAL_W-1:0]         inv_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] inv_vld_reg;
    logic                     inv_we;
    logic [TBL_AW-1:0]        inv_waddr;
    logic [TBL_AW-1:0]        inv_raddr;
    logic [VAL_W-1:0]         inv_rd_reg;
    logic                     inv_ok_reg;

    assign inv_we    = advance && mp_vld && (mp_tag.kind == KIND_LOAD)
                       && (mp_tag.ld_index < ALPHA_N) && (mp_tag.ld_value < ALPHA_N);
    assign inv_waddr = mp_tag.ld_value[TBL_AW-1:0];
    assign inv_raddr = aff_r[TBL_AW-1:0];

    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[inv_waddr] <= mp_tag.ld_index;
        end
        if (advance) begin
            inv_rd_reg <= inv_mem[inv_raddr];
            inv_ok_reg <= inv_vld_reg[inv_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_vld_reg <= '0;
        end else if (inv_we) begin
            inv_vld_reg[inv_waddr] <= 1'b1;
        end
    end

    // Inverse-read stage registers.
    logic             si_vld_reg;
    apc_tag_t         si_tag_reg;
    logic [VAL_W-1:0] si_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            si_vld_reg <= 1'b0;
        end else if (advance) begin
            si_vld_reg <= mp_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            si_tag_reg <= mp_tag;
            si_r_reg   <= aff_r;
        end
    end

    // Final value and result word.
    logic [VAL_W-1:0] fin_val;
    apc_out_t         out_next;

    always_comb begin
        fin_val = decrypt_reg ? permute(si_r_reg, use_table_reg, inv_ok_reg, inv_rd_reg)
                              : si_r_reg;
        if (si_tag_reg.letter) begin
            out_next.char_out   = ASCII_A + 8'(fin_val);
            out_next.was_letter = 1'b1;
        end else begin
            out_next.char_out   = si_tag_reg.ch;
            out_next.was_letter = 1'b0;
        end
    end

    // Output register.
    apc_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= si_vld_reg && (si_tag_reg.kind == KIND_CIPHER);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
